### sv/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// Shared types and constants for the length-prefixed slice deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package lpsd_pkg;

	localparam int unsigned DataWidth  = 8;
	localparam int unsigned LenWidth   = 32;
	localparam int unsigned GroupBits  = 7;
	localparam int unsigned MaxGroups  = 5;
	localparam int unsigned GroupCntW  = 3;
	localparam int unsigned AddrWidth  = 2;
	localparam int unsigned PDataWidth = 32;

	localparam logic [DataWidth-1:0] GROUP_MASK = 8'h7f;
	localparam logic [DataWidth-1:0] CONT_BIT   = 8'h80;

	// Byte address of the buffer length register
	localparam logic [AddrWidth-1:0] ADDR_BUFFER_LENGTH = 2'd0;

	// One result beat
	typedef struct packed {
		logic [DataWidth-1:0] payload_byte;
		logic                 payload_valid;
		logic [LenWidth-1:0]  slice_length;
		logic                 length_valid;
		logic                 slice_last;
		logic                 error;
	} result_t;

	// Bit offset of a header group; the group count wraps at five groups
	function automatic logic [5:0] group_shift(input logic [GroupCntW-1:0] cnt);
		logic [5:0] sh;
		case (cnt)
			3'd0:    sh = 6'd0;
			3'd1:    sh = 6'd7;
			3'd2:    sh = 6'd14;
			3'd3:    sh = 6'd21;
			3'd4:    sh = 6'd28;
			3'd5:    sh = 6'd0;
			3'd6:    sh = 6'd7;
			3'd7:    sh = 6'd14;
			default: sh = 6'd0;
		endcase
		return sh;
	endfunction

endpackage

`default_nettype wire

### sv/lpsd_cfg.sv
// ----------------------------------------------------------------------------
// lpsd_cfg
// APB register slave holding the buffer length.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               psel,
	input  wire logic                               penable,
	input  wire logic                               pwrite,
	input  wire logic [lpsd_pkg::AddrWidth-1:0]     paddr,
	input  wire logic [lpsd_pkg::PDataWidth-1:0]    pwdata,
	output logic      [lpsd_pkg::PDataWidth-1:0]    prdata,
	output logic                                    pready,
	output logic      [lpsd_pkg::LenWidth-1:0]      buffer_length
);

	logic [lpsd_pkg::LenWidth-1:0] buffer_length_q;
	logic                          wr_hit;

	assign pready = 1'b1;
	assign wr_hit = psel && penable && pwrite && (paddr == lpsd_pkg::ADDR_BUFFER_LENGTH);

	// Write the register on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buffer_length_q <= '0;
		end else if (wr_hit) begin
			buffer_length_q <= pwdata;
		end
	end

	// Read back
	always_comb begin
		if (paddr == lpsd_pkg::ADDR_BUFFER_LENGTH) begin
			prdata = buffer_length_q;
		end else begin
			prdata = '0;
		end
	end

	assign buffer_length = buffer_length_q;

endmodule

`default_nettype wire

### sv/lpsd_parse.sv
// ----------------------------------------------------------------------------
// lpsd_parse
// Per-byte parser: header accumulation, payload count, bound checks, error.
// ----------------------------------------------------------------------------
`default_nettype none

module lpsd_parse (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                step,
	input  wire logic [lpsd_pkg::DataWidth-1:0]      data_byte,
	input  wire logic                                restart,
	input  wire logic [lpsd_pkg::LenWidth-1:0]       buffer_length,
	output lpsd_pkg::result_t                        result
);

	logic [lpsd_pkg::LenWidth-1:0]  read_position_q, read_position_d;
	logic                           stream_ok_q, stream_ok_d;
	logic                           in_payload_q, in_payload_d;
	logic [lpsd_pkg::LenWidth-1:0]  length_accum_q, length_accum_d;
	logic [lpsd_pkg::GroupCntW-1:0] group_count_q, group_count_d;
	logic [lpsd_pkg::LenWidth-1:0]  payload_left_q, payload_left_d;

	// Effective state after an optional restart
	logic [lpsd_pkg::LenWidth-1:0]  pos_c;
	logic                           ok_c;
	logic                           inp_c;
	logic [lpsd_pkg::LenWidth-1:0]  acc_c;
	logic [lpsd_pkg::GroupCntW-1:0] gcnt_c;
	logic [lpsd_pkg::LenWidth-1:0]  left_c;

	logic [lpsd_pkg::LenWidth-1:0]  pos_inc;
	logic [lpsd_pkg::LenWidth-1:0]  room;
	logic [lpsd_pkg::LenWidth+6:0]  group_wide;
	logic [lpsd_pkg::LenWidth-1:0]  acc_new;
	logic [lpsd_pkg::GroupCntW-1:0] gcnt_inc;
	lpsd_pkg::result_t              res;

	assign pos_c  = restart ? '0   : read_position_q;
	assign ok_c   = restart ? 1'b1 : stream_ok_q;
	assign inp_c  = restart ? 1'b0 : in_payload_q;
	assign acc_c  = restart ? '0   : length_accum_q;
	assign gcnt_c = restart ? '0   : group_count_q;
	assign left_c = restart ? '0   : payload_left_q;

	assign pos_inc    = pos_c + 1'b1;
	assign room       = buffer_length - pos_inc;
	assign group_wide = {{(lpsd_pkg::LenWidth-1){1'b0}}, data_byte & lpsd_pkg::GROUP_MASK}
		<< lpsd_pkg::group_shift(gcnt_c);
	assign acc_new    = acc_c | group_wide[lpsd_pkg::LenWidth-1:0];
	assign gcnt_inc   = gcnt_c + 1'b1;

	// Next state and result for one byte
	always_comb begin
		read_position_d = pos_c;
		stream_ok_d     = ok_c;
		in_payload_d    = inp_c;
		length_accum_d  = acc_c;
		group_count_d   = gcnt_c;
		payload_left_d  = left_c;
		res             = '0;

		if (ok_c) begin
			if (pos_c >= buffer_length) begin
				stream_ok_d = 1'b0;
			end else begin
				read_position_d = pos_inc;
				if (inp_c) begin
					res.payload_byte  = data_byte;
					res.payload_valid = 1'b1;
					payload_left_d    = left_c - 1'b1;
					if (left_c == {{(lpsd_pkg::LenWidth-1){1'b0}}, 1'b1}) begin
						in_payload_d   = 1'b0;
						res.slice_last = 1'b1;
					end
				end else if ((data_byte & lpsd_pkg::CONT_BIT) == '0) begin
					// Header complete: check the length against the bytes left
					length_accum_d = '0;
					group_count_d  = '0;
					if (acc_new > room) begin
						stream_ok_d = 1'b0;
					end else begin
						res.slice_length = acc_new;
						res.length_valid = 1'b1;
						if (acc_new == '0) begin
							res.slice_last = 1'b1;
						end else begin
							in_payload_d   = 1'b1;
							payload_left_d = acc_new;
						end
					end
				end else if (gcnt_inc >= lpsd_pkg::GroupCntW'(lpsd_pkg::MaxGroups)) begin
					// Sixth group would follow: too-long header
					length_accum_d = '0;
					group_count_d  = '0;
					stream_ok_d    = 1'b0;
				end else begin
					length_accum_d = acc_new;
					group_count_d  = gcnt_inc;
				end
			end
		end

		// Blank every field once in error
		if (!stream_ok_d) begin
			res = '0;
		end
		res.error = !stream_ok_d;
	end

	assign result = res;

	// Advance the parser state on each byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			read_position_q <= '0;
			stream_ok_q     <= 1'b1;
			in_payload_q    <= 1'b0;
			length_accum_q  <= '0;
			group_count_q   <= '0;
			payload_left_q  <= '0;
		end else if (step) begin
			read_position_q <= read_position_d;
			stream_ok_q     <= stream_ok_d;
			in_payload_q    <= in_payload_d;
			length_accum_q  <= length_accum_d;
			group_count_q   <= group_count_d;
			payload_left_q  <= payload_left_d;
		end
	end

endmodule

`default_nettype wire

### sv/length_prefixed_slice_deframer.sv
// ----------------------------------------------------------------------------
// length_prefixed_slice_deframer
// Splits a byte buffer into LEB128 length-prefixed slices, one byte a beat.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------------------
//  in       | in_valid/in_stall  | data_byte, restart
//  out      | out_valid/out_stall| payload_byte, payload_valid, slice_length,
//           |                    | length_valid, slice_last, error
//  config   | APB                | buffer_length at address 0
//
//  One byte a cycle sustained while the output is not stalled; each beat
//  passes an input register, then the parser logic into the output register.
//  The parser state updates when a beat moves into the output register.
//  Reset clears the parser state and sets buffer_length to zero.
//  A stalled output holds its beat; the input register still takes one beat.
// ----------------------------------------------------------------------------
`default_nettype none

module length_prefixed_slice_deframer (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lpsd_pkg::AddrWidth-1:0]    paddr,
	input  wire logic [lpsd_pkg::PDataWidth-1:0]   pwdata,
	output logic      [lpsd_pkg::PDataWidth-1:0]   prdata,
	output logic                                   pready,
	// input bytes
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [lpsd_pkg::DataWidth-1:0]    data_byte,
	input  wire logic                              restart,
	// results
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic      [lpsd_pkg::DataWidth-1:0]    payload_byte,
	output logic                                   payload_valid,
	output logic      [lpsd_pkg::LenWidth-1:0]     slice_length,
	output logic                                   length_valid,
	output logic                                   slice_last,
	output logic                                   error
);

	logic [lpsd_pkg::LenWidth-1:0]  buffer_length;
	logic                           valid_s1;
	logic [lpsd_pkg::DataWidth-1:0] data_byte_s1;
	logic                           restart_s1;
	logic                           out_valid_q;
	lpsd_pkg::result_t              result_c;
	lpsd_pkg::result_t              result_q;
	logic                           out_busy;
	logic                           advance;

	lpsd_cfg u_cfg (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.buffer_length(buffer_length)
	);

	assign out_busy = out_valid_q && out_stall;
	assign advance  = valid_s1 && !out_busy;
	assign in_stall = valid_s1 && out_busy;

	// Input register: take a beat whenever it is empty or draining
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			data_byte_s1 <= data_byte;
			restart_s1   <= restart;
		end
	end

	lpsd_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.data_byte    (data_byte_s1),
		.restart      (restart_s1),
		.buffer_length(buffer_length),
		.result       (result_c)
	);

	// Output register: load on advance, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign payload_byte  = result_q.payload_byte;
	assign payload_valid = result_q.payload_valid;
	assign slice_length  = result_q.slice_length;
	assign length_valid  = result_q.length_valid;
	assign slice_last    = result_q.slice_last;
	assign error         = result_q.error;

endmodule

`default_nettype wire

### tb/lpsd_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lpsd_checker
// Watches the byte, result and register ports of the deframer. Keeps its own
// copy of the header and payload parser, predicts one result beat per
// accepted byte and compares each result beat field by field.
// ----------------------------------------------------------------------------

module lpsd_checker (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration port
	input  wire logic                              psel,
	input  wire logic                              penable,
	input  wire logic                              pwrite,
	input  wire logic [lpsd_pkg::AddrWidth-1:0]    paddr,
	input  wire logic [lpsd_pkg::PDataWidth-1:0]   pwdata,
	input  wire logic [lpsd_pkg::PDataWidth-1:0]   prdata,
	input  wire logic                              pready,
	// byte channel
	input  wire logic                              in_valid,
	input  wire logic                              in_stall,
	input  wire logic [lpsd_pkg::DataWidth-1:0]    data_byte,
	input  wire logic                              restart,
	// result channel
	input  wire logic                              out_valid,
	input  wire logic                              out_stall,
	input  wire logic [lpsd_pkg::DataWidth-1:0]    payload_byte,
	input  wire logic                              payload_valid,
	input  wire logic [lpsd_pkg::LenWidth-1:0]     slice_length,
	input  wire logic                              length_valid,
	input  wire logic                              slice_last,
	input  wire logic                              error,
	// status to the testbench top
	output int                                     fail_count,
	output int                                     pending,
	output int                                     result_count
);

	// Parser copy
	logic [lpsd_pkg::LenWidth-1:0]  buf_len;
	logic [lpsd_pkg::LenWidth-1:0]  rd_pos;
	logic [lpsd_pkg::LenWidth-1:0]  acc;
	logic [lpsd_pkg::LenWidth-1:0]  body_left;
	logic [lpsd_pkg::GroupCntW-1:0] groups;
	logic                           ok;
	logic                           in_body;

	lpsd_pkg::result_t beats_due[$];
	lpsd_pkg::result_t seen;
	lpsd_pkg::result_t want;

	function automatic void clear_parse_state();
		rd_pos    = '0;
		ok        = 1'b1;
		in_body   = 1'b0;
		acc       = '0;
		groups    = '0;
		body_left = '0;
	endfunction

	// Advance the parser by one byte and return the beat it reports
	function automatic lpsd_pkg::result_t parse_byte(
			input logic [lpsd_pkg::DataWidth-1:0] b, input logic rst);
		lpsd_pkg::result_t             r;
		int unsigned                   sh;
		logic [lpsd_pkg::LenWidth-1:0] len;
		r = '0;
		if (rst)
			clear_parse_state();
		if (ok) begin
			if (rd_pos >= buf_len) begin
				// overrun: byte is not consumed
				ok = 1'b0;
			end else begin
				rd_pos = rd_pos + 1;
				if (in_body) begin
					r.payload_byte  = b;
					r.payload_valid = 1'b1;
					body_left       = body_left - 1;
					if (body_left == 0) begin
						in_body      = 1'b0;
						r.slice_last = 1'b1;
					end
				end else begin
					// bits shifted past bit 31 fall off
					sh     = (groups % lpsd_pkg::MaxGroups) * lpsd_pkg::GroupBits;
					acc    = acc | ({24'b0, b & lpsd_pkg::GROUP_MASK} << sh);
					groups = groups + 1'b1;
					if ((b & lpsd_pkg::CONT_BIT) == 0) begin
						len    = acc;
						acc    = '0;
						groups = '0;
						if (len > buf_len - rd_pos) begin
							ok = 1'b0;
						end else begin
							r.slice_length = len;
							r.length_valid = 1'b1;
							if (len == 0) begin
								r.slice_last = 1'b1;
							end else begin
								in_body   = 1'b1;
								body_left = len;
							end
						end
					end else if (groups >= lpsd_pkg::MaxGroups) begin
						// continuation on the fifth group
						acc    = '0;
						groups = '0;
						ok     = 1'b0;
					end
				end
			end
		end
		if (!ok)
			r = '0;
		r.error = !ok;
		return r;
	endfunction

	task automatic check_field(input string name, input logic [31:0] exp_v,
			input logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_len = '0;
			clear_parse_state();
			beats_due.delete();
			fail_count   = 0;
			pending      = 0;
			result_count = 0;
		end else begin
			// compare a result beat with the oldest prediction
			if (out_valid && !out_stall) begin
				result_count++;
				seen = '{payload_byte, payload_valid, slice_length, length_valid,
					slice_last, error};
				if (beats_due.size() == 0) begin
					$error("result beat with no byte waiting for it");
					fail_count++;
				end else begin
					want = beats_due.pop_front();
					check_field("payload_byte", 32'(want.payload_byte), 32'(seen.payload_byte));
					check_field("payload_valid", 32'(want.payload_valid),
						32'(seen.payload_valid));
					check_field("slice_length", want.slice_length, seen.slice_length);
					check_field("length_valid", 32'(want.length_valid),
						32'(seen.length_valid));
					check_field("slice_last", 32'(want.slice_last), 32'(seen.slice_last));
					check_field("error", 32'(want.error), 32'(seen.error));
				end
			end
			// track register writes, check read-back
			if (psel && penable && pready && paddr == lpsd_pkg::ADDR_BUFFER_LENGTH) begin
				if (pwrite)
					buf_len = pwdata;
				else
					check_field("prdata", buf_len, prdata);
			end
			// predict the beat for an accepted byte
			if (in_valid && !in_stall)
				beats_due.push_back(parse_byte(data_byte, restart));
			pending = beats_due.size();
		end
	end

endmodule

### tb/tb_length_prefixed_slice_deframer.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_slice_deframer
// Drives byte buffers of LEB128 length-prefixed slices into the deframer:
// directed corner buffers first, then random well-formed, truncated,
// too-long-header and noise buffers, with bursty input, a stalling output
// and buffer length writes between buffers. The checker does the scoring.
// ----------------------------------------------------------------------------

module tb_length_prefixed_slice_deframer;

	localparam int unsigned RunLimitNs = 3000000;
	localparam int unsigned HoldCycles = 64;

	typedef struct packed {
		logic [lpsd_pkg::DataWidth-1:0] b;
		logic                           first;
	} stream_byte_t;

	logic                            clk;
	logic                            arst_n;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [lpsd_pkg::AddrWidth-1:0]  paddr;
	logic [lpsd_pkg::PDataWidth-1:0] pwdata;
	logic [lpsd_pkg::PDataWidth-1:0] prdata;
	logic                            pready;
	logic                            in_valid;
	logic                            in_stall;
	logic [lpsd_pkg::DataWidth-1:0]  data_byte;
	logic                            restart;
	logic                            out_valid;
	logic                            out_stall;
	logic [lpsd_pkg::DataWidth-1:0]  payload_byte;
	logic                            payload_valid;
	logic [lpsd_pkg::LenWidth-1:0]   slice_length;
	logic                            length_valid;
	logic                            slice_last;
	logic                            error;

	int fail_count;
	int pending;
	int result_count;

	stream_byte_t stream_q[$];
	int beats_sent;
	int nbuf;
	int writes;
	int hold_req;
	int hold_done;

	length_prefixed_slice_deframer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.payload_valid(payload_valid),
		.slice_length (slice_length),
		.length_valid (length_valid),
		.slice_last   (slice_last),
		.error        (error)
	);

	lpsd_checker u_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.restart      (restart),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.payload_byte (payload_byte),
		.payload_valid(payload_valid),
		.slice_length (slice_length),
		.length_valid (length_valid),
		.slice_last   (slice_last),
		.error        (error),
		.fail_count   (fail_count),
		.pending      (pending),
		.result_count (result_count)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop
	initial begin
		#(RunLimitNs);
		$display("length_prefixed_slice_deframer: mismatch");
		$finish;
	end

	// Output stall pattern, with a long hold-off on request
	initial begin
		int seg;
		int mode;
		int cnt;
		out_stall <= 1'b0;
		cnt = 0;
		forever begin
			mode = $urandom_range(0, 3);
			seg  = $urandom_range(16, 96);
			repeat (seg) begin
				@(negedge clk);
				if (hold_req != hold_done) begin
					out_stall <= 1'b1;
					repeat (HoldCycles) @(negedge clk);
					hold_done++;
				end
				cnt++;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 99) < 30);
					2: out_stall <= (cnt % 4 == 3);
					default: out_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
		end
	end

	task automatic push_byte(input logic [lpsd_pkg::DataWidth-1:0] b, input logic first);
		stream_q.push_back('{b, first});
	endtask

	// Raise restart on the first byte of the queued buffer
	task automatic mark_first();
		stream_byte_t it;
		if (stream_q.size() > 0) begin
			it       = stream_q[0];
			it.first = 1'b1;
			stream_q[0] = it;
		end
	endtask

	// Queue an LEB128 header, sometimes padded out to more groups
	task automatic push_header(input logic [lpsd_pkg::LenWidth-1:0] len);
		int ng;
		int i;
		logic [lpsd_pkg::DataWidth-1:0] g;
		ng = 1;
		while (ng < lpsd_pkg::MaxGroups && (len >> (lpsd_pkg::GroupBits * ng)) != 0)
			ng++;
		if ($urandom_range(0, 4) == 0)
			ng = $urandom_range(ng, lpsd_pkg::MaxGroups);
		for (i = 0; i < ng; i++) begin
			g = 8'(len >> (lpsd_pkg::GroupBits * i)) & lpsd_pkg::GROUP_MASK;
			if (i < ng - 1)
				g = g | lpsd_pkg::CONT_BIT;
			else if (ng == lpsd_pkg::MaxGroups && $urandom_range(0, 1) == 1)
				g = g | {1'b0, 3'($urandom), 4'b0};
			push_byte(g, 1'b0);
		end
	endtask

	// Queue n slices with random payload, mostly short
	task automatic build_slices(input int n);
		int r;
		int len;
		repeat (n) begin
			r = $urandom_range(0, 99);
			if (r < 70)
				len = $urandom_range(0, 4);
			else if (r < 90)
				len = $urandom_range(5, 12);
			else
				len = $urandom_range(128, 160);
			push_header(32'(len));
			repeat (len) push_byte(8'($urandom), 1'b0);
		end
	endtask

	// Drop valid, with junk on the payload lines
	task automatic idle_in(input int n);
		@(negedge clk);
		in_valid  <= 1'b0;
		data_byte <= 8'($urandom);
		restart   <= 1'($urandom);
		repeat (n - 1) @(negedge clk);
	endtask

	// Send count queued bytes, in bursts when gappy
	task automatic send_stream(input bit gappy, input int count);
		stream_byte_t it;
		int burst;
		burst = $urandom_range(1, 16);
		repeat (count) begin
			it = stream_q.pop_front();
			@(negedge clk);
			in_valid  <= 1'b1;
			data_byte <= it.b;
			restart   <= it.first;
			@(posedge clk);
			while (in_stall) @(posedge clk);
			beats_sent++;
			burst--;
			if (gappy && burst == 0) begin
				idle_in($urandom_range(1, 6));
				burst = $urandom_range(1, 16);
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait until every predicted beat has come out
	task automatic settle();
		while (pending != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Write buffer_length, then read it back
	task automatic reg_write(input logic [lpsd_pkg::PDataWidth-1:0] v);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= lpsd_pkg::ADDR_BUFFER_LENGTH;
		pwdata  <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		writes++;
	endtask

	initial begin
		int kind;
		int split;
		int drop;
		int r;
		int guard;
		logic [lpsd_pkg::PDataWidth-1:0] cfg;

		arst_n    = 1'b0;
		psel      <= 1'b0;
		penable   <= 1'b0;
		pwrite    <= 1'b0;
		paddr     <= '0;
		pwdata    <= '0;
		in_valid  <= 1'b0;
		data_byte <= '0;
		restart   <= 1'b0;
		beats_sent = 0;
		nbuf       = 0;
		writes     = 0;
		hold_req   = 0;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// zero buffer length out of reset: every byte overruns
		push_byte(8'h00, 1'b1);
		push_byte(8'hff, 1'b0);
		send_stream(0, stream_q.size());
		settle();
		reg_write(32'hffff_ffff);

		// empty slice, then a five-group near-maximum length
		push_byte(8'h00, 1'b1);
		push_byte(8'hf0, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h0f, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(8'hff, 1'b0);
		// length past the end of the buffer
		push_byte(8'hff, 1'b1);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h0f, 1'b0);
		// continuation on the fifth group
		push_byte(8'h80, 1'b1);
		repeat (lpsd_pkg::MaxGroups - 1) push_byte(lpsd_pkg::CONT_BIT, 1'b0);
		push_byte(8'h01, 1'b0);
		// fifth group with bits above bit 31
		push_byte(8'h82, 1'b1);
		push_byte(8'h80, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h70, 1'b0);
		push_byte(8'hff, 1'b0);
		push_byte(8'h00, 1'b0);
		send_stream(0, stream_q.size());

		// exact buffer, then grow the bound mid-buffer and overrun it
		settle();
		reg_write(32'd3);
		push_byte(8'h02, 1'b1);
		push_byte(8'haa, 1'b0);
		push_byte(8'h55, 1'b0);
		send_stream(0, stream_q.size());
		settle();
		reg_write(32'd5);
		push_byte(8'h01, 1'b0);
		push_byte(8'h7e, 1'b0);
		push_byte(8'h00, 1'b0);
		send_stream(0, stream_q.size());

		// random buffers, one register setting each, another before the rest of a split buffer
		while (beats_sent < 520) begin
			kind  = $urandom_range(0, 99);
			split = 0;
			nbuf++;
			if (kind < 60 || nbuf == 6 || nbuf == 18) begin
				// well-formed
				build_slices((nbuf == 6 || nbuf == 18) ? 8 : $urandom_range(1, 5));
				mark_first();
				cfg = stream_q.size();
				if ($urandom_range(0, 3) == 0)
					cfg = cfg + $urandom_range(1, 4);
				if ($urandom_range(0, 6) == 0 && stream_q.size() > 1)
					split = $urandom_range(1, stream_q.size() - 1);
			end else if (kind < 75) begin
				// bound too short: overrun or overlong length
				build_slices($urandom_range(1, 4));
				mark_first();
				drop = $urandom_range(1, 3);
				cfg  = (stream_q.size() > drop) ? stream_q.size() - drop : 0;
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
			end else if (kind < 85) begin
				// header that never ends
				build_slices($urandom_range(0, 2));
				repeat (lpsd_pkg::MaxGroups)
					push_byte(lpsd_pkg::CONT_BIT | 8'($urandom), 1'b0);
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom), 1'b0);
				mark_first();
				cfg = stream_q.size() + $urandom_range(0, 8);
			end else begin
				// noise with stray restarts
				repeat ($urandom_range(6, 20))
					push_byte(8'($urandom), 1'($urandom_range(0, 99) < 15));
				if ($urandom_range(0, 1) == 1)
					mark_first();
				r = $urandom_range(0, 3);
				if (r < 2)
					cfg = $urandom_range(0, 30);
				else if (r == 2)
					cfg = $urandom;
				else
					cfg = ($urandom_range(0, 1) == 1) ? 32'hffff_ffff : 32'h0;
			end
			settle();
			reg_write(cfg);
			if (nbuf == 6 || nbuf == 18)
				hold_req++;
			if (split != 0) begin
				send_stream(1, split);
				settle();
				reg_write(cfg + $urandom_range(0, 2));
			end
			send_stream($urandom_range(0, 3) != 0, stream_q.size());
		end

		// drain
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(negedge clk);
			guard++;
		end
		if (pending != 0) begin
			$display("length_prefixed_slice_deframer: mismatch");
			$finish;
		end else begin
			repeat (8) @(negedge clk);
			$display("covered %0d input beats over %0d random buffers, %0d result beats checked",
				beats_sent, nbuf, result_count);
			$display("%0d buffer length writes, %0d long output hold-offs",
				writes, hold_done);
			if (fail_count == 0 && pending == 0)
				$display("length_prefixed_slice_deframer: match");
			else
				$display("length_prefixed_slice_deframer: mismatch");
			$finish;
		end
	end

endmodule
